// ----- sv/fee_pkg.sv -----
// ============================================================================
// fee_pkg
// Shared types, codes and constants of the two-page flash EEPROM emulation.
// ============================================================================
`default_nettype none

package fee_pkg;

    localparam int PAGE_SLOTS_DEF  = 256;
    localparam int TABLE_DEPTH_DEF = 16;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int SLOTS_CFG_W = 9;
    localparam int VAR_CFG_W   = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_COUNT    = 2'd1;

    localparam logic [15:0] HDR_ERASED  = 16'hFFFF;
    localparam logic [15:0] HDR_RECEIVE = 16'hEEEE;
    localparam logic [15:0] HDR_VALID   = 16'h0000;
    localparam logic [31:0] SLOT_ERASED = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_LOAD  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NO_PAGE   = 2'd3
    } t_status;

    // Answer of the slot scanner, valid for the single cycle that done is high.
    typedef struct packed {
        logic        done;
        logic        found;
        logic [15:0] data;
    } t_scan_rsp;

endpackage

`default_nettype wire

// ----- sv/fee_item_if.sv -----
// ============================================================================
// fee_item_if
// Input word channel: item kind, virtual address, write data, table index.
// ============================================================================
`default_nettype none

interface fee_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] var_addr;
    logic [15:0] write_data;
    logic [3:0]  table_index;

    modport source (output valid, kind, var_addr, write_data, table_index, input ready);
    modport sink   (input valid, kind, var_addr, write_data, table_index, output ready);
endinterface

`default_nettype wire

// ----- sv/fee_result_if.sv -----
// ============================================================================
// fee_result_if
// Result word channel: status, read data and the page transfer flag.
// ============================================================================
`default_nettype none

interface fee_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] read_data;
    logic        transferred;

    modport source (output valid, status, read_data, transferred, input ready);
    modport sink   (input valid, status, read_data, transferred, output ready);
endinterface

`default_nettype wire

// ----- sv/fee_cfg_if.sv -----
// ============================================================================
// fee_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
`default_nettype none

interface fee_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fee_pkg::CFG_IDX_W-1:0]  index;
    logic [fee_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/fee_ram.sv -----
// ============================================================================
// fee_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
`default_nettype none

module fee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

`default_nettype wire

// ----- sv/fee_scan.sv -----
// ============================================================================
// fee_scan
// Slot scanner: walks one page from its last used slot down to slot 1 and
// reports the newest slot whose virtual address matches.
// ============================================================================
`default_nettype none

module fee_scan #(
    parameter int PAGE_SLOTS = fee_pkg::PAGE_SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_page,
    input  wire logic [15:0]                   i_addr,
    input  wire logic [$clog2(PAGE_SLOTS):0]   i_used,
    input  wire logic [$clog2(PAGE_SLOTS):0]   i_fill,
    output logic                               o_rd_en,
    output logic      [$clog2(PAGE_SLOTS):0]   o_rd_addr,
    input  wire logic [31:0]                   i_rd_data,
    output fee_pkg::t_scan_rsp                 o_rsp
);
    import fee_pkg::*;

    localparam int SW = $clog2(PAGE_SLOTS);
    localparam int NW = SW + 1;

    typedef enum logic [1:0] {
        SC_IDLE = 2'b01,
        SC_RUN  = 2'b10
    } t_sc_state;

    t_sc_state         r_state, n_state;
    logic              r_page, n_page;
    logic [15:0]       r_addr, n_addr;
    logic [NW-1:0]     r_fill, n_fill;
    logic [SW-1:0]     r_slot, n_slot;
    logic [SW-1:0]     r_pslot, n_pslot;
    logic              r_pend, n_pend;
    logic [31:0]       w_word;
    logic              w_hit;

    // Slots at or above the fill mark were never written since the last erase.
    assign w_word = ({1'b0, r_pslot} >= r_fill) ? SLOT_ERASED : i_rd_data;
    assign w_hit  = r_pend && (w_word[31:16] == r_addr);

    always_comb begin
        n_state   = r_state;
        n_page    = r_page;
        n_addr    = r_addr;
        n_fill    = r_fill;
        n_slot    = r_slot;
        n_pslot   = r_pslot;
        n_pend    = r_pend;
        o_rd_en   = 1'b0;
        o_rd_addr = {r_page, r_slot};
        o_rsp     = '0;
        case (r_state)
            SC_IDLE: begin
                if (i_start) begin
                    n_state = SC_RUN;
                    n_page  = i_page;
                    n_addr  = i_addr;
                    n_fill  = i_fill;
                    n_slot  = SW'(i_used - NW'(1));
                    n_pend  = 1'b0;
                end
            end
            SC_RUN: begin
                if (w_hit) begin
                    o_rsp.done  = 1'b1;
                    o_rsp.found = 1'b1;
                    o_rsp.data  = w_word[15:0];
                    n_state     = SC_IDLE;
                    n_pend      = 1'b0;
                end else if (r_pend && (r_pslot == SW'(1))) begin
                    o_rsp.done = 1'b1;
                    n_state    = SC_IDLE;
                    n_pend     = 1'b0;
                end else begin
                    // Read the next slot down while the current one is compared.
                    o_rd_en = 1'b1;
                    n_pslot = r_slot;
                    n_pend  = 1'b1;
                    n_slot  = r_slot - SW'(1);
                end
            end
            default: begin
                n_state = SC_IDLE;
                n_pend  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page  <= n_page;
        r_addr  <= n_addr;
        r_fill  <= n_fill;
        r_slot  <= n_slot;
        r_pslot <= n_pslot;
    end

`ifndef SYNTHESIS
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.found |-> o_rsp.done)
        else $error("scan found without done");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !o_rsp.done)
        else $error("scan done held for two cycles");
    a_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SC_RUN && r_pend) |-> (r_pslot != '0))
        else $error("scan reached the header slot");
`endif
endmodule

`default_nettype wire

// ----- sv/flash_eeprom_emulation.sv -----
// ============================================================================
// flash_eeprom_emulation
// EEPROM emulation in two flash pages with append writes, newest-first reads
// and page transfer when the active page fills.
// ============================================================================
// Usage. Items arrive on i_item (valid/ready). Kind 0 reads a variable, kind
// 1 writes one, kind 2 loads an entry of the virtual address table, and kind
// 3 does nothing. Every item returns exactly one result word on o_result.
// i_cfg writes slots_in_use (index 0) and var_count (index 1); it is always
// ready and should only be used while the block is idle.
//
// Flow. A read scans the valid page for its address, returns its result
// when the scan ends and frees the input once back in S_IDLE; the slot
// scanner fetches one slot from the page memory per cycle and stops early
// on a match. A write that finds room appends its pair in S_WRITE and
// answers. A write that fills the page runs a transfer: per table entry a
// table step, a scan of the old page and, if the scan finds the address, a
// copy step; its result comes when the transfer ends. One item is
// processed at a time; i_item.ready is low while an item is at work.
//
// Reset. Page 0 comes up valid and page 1 erased. Both page fill marks go to
// slot 1, so the page memory needs no clearing pass: every slot at or above
// a page's fill mark reads as erased. The table is undefined until loaded.
// A stalled receiver holds the result in the output register; the next item
// is taken in the cycle the pending result leaves.
// ============================================================================
`default_nettype none

module flash_eeprom_emulation #(
    parameter int PAGE_SLOTS  = fee_pkg::PAGE_SLOTS_DEF,
    parameter int TABLE_DEPTH = fee_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fee_item_if.sink    i_item,
    fee_cfg_if.sink     i_cfg,
    fee_result_if.source o_result
);
    import fee_pkg::*;

    localparam int SW = $clog2(PAGE_SLOTS);
    localparam int NW = SW + 1;
    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_READ     = 8'b0000_0010,
        S_WRITE    = 8'b0000_0100,
        S_XF_FIRST = 8'b0000_1000,
        S_XF_TBL   = 8'b0001_0000,
        S_XF_SCAN  = 8'b0010_0000,
        S_XF_COPY  = 8'b0100_0000,
        S_XF_END   = 8'b1000_0000
    } t_state;

    t_state                 r_state, n_state;
    logic [15:0]            r_hdr [2];
    logic [15:0]            n_hdr [2];
    logic [NW-1:0]          r_fill [2];
    logic [NW-1:0]          n_fill [2];
    logic [SLOTS_CFG_W-1:0] r_slots_cfg, n_slots_cfg;
    logic [VAR_CFG_W-1:0]   r_var_cfg, n_var_cfg;
    logic                   r_out_valid, n_out_valid;
    t_status                r_out_status, n_out_status;
    logic [15:0]            r_out_rdata, n_out_rdata;
    logic                   r_out_moved, n_out_moved;

    // Payload registers.
    logic [15:0]            r_addr, n_addr;
    logic [15:0]            r_data, n_data;
    logic                   r_old, n_old;
    logic [CW-1:0]          r_i, n_i;
    logic [15:0]            r_cp_addr, n_cp_addr;
    logic [15:0]            r_cp_data, n_cp_data;
    logic [15:0]            r_table [TABLE_DEPTH];

    logic                   w_item_acc;
    logic [NW-1:0]          w_used;
    logic [CW-1:0]          w_cnt;
    logic                   w_rp_none, w_rp;
    logic                   w_wp_none, w_wp;
    logic                   w_app_do, w_app_page, w_app_full;
    logic [31:0]            w_app_word;
    logic                   w_wen;
    logic                   w_tbl_we;
    logic [TW-1:0]          w_tbl_idx;
    logic [15:0]            w_tval;
    logic                   w_scan_start, w_scan_page;
    logic [15:0]            w_scan_addr;
    logic                   w_rd_en;
    logic [NW-1:0]          w_rd_addr;
    logic [31:0]            w_rd_data;
    t_scan_rsp              w_rsp;

    assign i_item.ready = (r_state == S_IDLE) && (!r_out_valid || o_result.ready);
    assign w_item_acc   = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_out_status;
    assign o_result.read_data   = r_out_rdata;
    assign o_result.transferred = r_out_moved;

    // Clamp the configuration to the ranges the page and table support.
    always_comb begin
        if (r_slots_cfg < SLOTS_CFG_W'(2)) begin
            w_used = NW'(2);
        end else if (int'(r_slots_cfg) > PAGE_SLOTS) begin
            w_used = NW'(PAGE_SLOTS);
        end else begin
            w_used = NW'(r_slots_cfg);
        end
        if (int'(r_var_cfg) > TABLE_DEPTH) begin
            w_cnt = CW'(TABLE_DEPTH);
        end else begin
            w_cnt = CW'(r_var_cfg);
        end
    end

    // Reads come from the valid page, page 0 first. Writes go to the page
    // that is receiving if a transfer is open, else to the valid page.
    always_comb begin
        w_rp_none = 1'b0;
        w_rp      = 1'b0;
        if (r_hdr[0] == HDR_VALID) begin
            w_rp = 1'b0;
        end else if (r_hdr[1] == HDR_VALID) begin
            w_rp = 1'b1;
        end else begin
            w_rp_none = 1'b1;
        end
        w_wp_none = 1'b0;
        w_wp      = 1'b0;
        if (r_hdr[1] == HDR_VALID) begin
            w_wp = (r_hdr[0] == HDR_RECEIVE) ? 1'b0 : 1'b1;
        end else if (r_hdr[0] == HDR_VALID) begin
            w_wp = (r_hdr[1] == HDR_RECEIVE) ? 1'b1 : 1'b0;
        end else begin
            w_wp_none = 1'b1;
        end
    end

    assign w_tval     = r_table[r_i[TW-1:0]];
    assign w_app_full = (r_fill[w_app_page] >= w_used);
    assign w_wen      = w_app_do && !w_app_full;
    assign w_tbl_idx  = TW'(i_item.table_index);
    assign w_tbl_we   = w_item_acc && (i_item.kind == KIND_LOAD)
                        && (int'(i_item.table_index) < TABLE_DEPTH);

    always_comb begin
        n_state      = r_state;
        n_hdr        = r_hdr;
        n_fill       = r_fill;
        n_slots_cfg  = r_slots_cfg;
        n_var_cfg    = r_var_cfg;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_rdata  = r_out_rdata;
        n_out_moved  = r_out_moved;
        n_addr       = r_addr;
        n_data       = r_data;
        n_old        = r_old;
        n_i          = r_i;
        n_cp_addr    = r_cp_addr;
        n_cp_data    = r_cp_data;
        w_scan_start = 1'b0;
        w_scan_page  = w_rp;
        w_scan_addr  = r_addr;
        w_app_do     = 1'b0;
        w_app_page   = ~r_old;
        w_app_word   = {r_addr, r_data};

        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SLOTS_IN_USE: n_slots_cfg = i_cfg.data[SLOTS_CFG_W-1:0];
                CFG_VAR_COUNT:    n_var_cfg   = i_cfg.data[VAR_CFG_W-1:0];
                default:          ;
            endcase
        end

        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_item_acc) begin
                    n_addr       = i_item.var_addr;
                    n_data       = i_item.write_data;
                    n_out_status = STAT_OK;
                    n_out_rdata  = '0;
                    n_out_moved  = 1'b0;
                    case (i_item.kind)
                        KIND_READ: begin
                            if (w_rp_none) begin
                                n_out_valid  = 1'b1;
                                n_out_status = STAT_NO_PAGE;
                            end else begin
                                w_scan_start = 1'b1;
                                w_scan_page  = w_rp;
                                w_scan_addr  = i_item.var_addr;
                                n_state      = S_READ;
                            end
                        end
                        KIND_WRITE: begin
                            n_state = S_WRITE;
                        end
                        default: begin
                            // Table loads and the unused kind answer at once.
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (w_rsp.done) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (w_rsp.found) begin
                        n_out_rdata = w_rsp.data;
                    end else begin
                        n_out_status = STAT_NOT_FOUND;
                    end
                end
            end
            S_WRITE: begin
                w_app_page = w_wp;
                w_app_do   = !w_wp_none;
                if (w_wp_none) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_NO_PAGE;
                    n_state      = S_IDLE;
                end else if (!w_app_full) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    // Page full: open a transfer into the other page.
                    n_out_moved = 1'b1;
                    if (w_rp_none) begin
                        n_out_valid  = 1'b1;
                        n_out_status = STAT_NO_PAGE;
                        n_state      = S_IDLE;
                    end else begin
                        n_hdr[~w_rp] = HDR_RECEIVE;
                        n_old        = w_rp;
                        n_state      = S_XF_FIRST;
                    end
                end
            end
            S_XF_FIRST: begin
                w_app_do = 1'b1;
                if (w_app_full) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_FULL;
                    n_state      = S_IDLE;
                end else begin
                    n_i     = '0;
                    n_state = S_XF_TBL;
                end
            end
            S_XF_TBL: begin
                if (r_i >= w_cnt) begin
                    n_state = S_XF_END;
                end else if (w_tval == r_addr) begin
                    // The new pair already went in first.
                    n_i = r_i + CW'(1);
                end else begin
                    w_scan_start = 1'b1;
                    w_scan_page  = r_old;
                    w_scan_addr  = w_tval;
                    n_cp_addr    = w_tval;
                    n_state      = S_XF_SCAN;
                end
            end
            S_XF_SCAN: begin
                if (w_rsp.done) begin
                    if (w_rsp.found) begin
                        n_cp_data = w_rsp.data;
                        n_state   = S_XF_COPY;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_XF_TBL;
                    end
                end
            end
            S_XF_COPY: begin
                w_app_do   = 1'b1;
                w_app_word = {r_cp_addr, r_cp_data};
                if (w_app_full) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_FULL;
                    n_state      = S_IDLE;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_XF_TBL;
                end
            end
            S_XF_END: begin
                // Erasing the old page is just a reset of its fill mark.
                n_fill[r_old] = NW'(1);
                n_hdr[r_old]  = HDR_ERASED;
                n_hdr[~r_old] = HDR_VALID;
                n_out_valid   = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A pair that looks erased leaves the slot erased, so the mark stays.
        if (w_wen && (w_app_word != SLOT_ERASED)) begin
            n_fill[w_app_page] = r_fill[w_app_page] + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hdr[0]    <= HDR_VALID;
            r_hdr[1]    <= HDR_ERASED;
            r_fill[0]   <= NW'(1);
            r_fill[1]   <= NW'(1);
            r_slots_cfg <= SLOTS_CFG_W'(256);
            r_var_cfg   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hdr       <= n_hdr;
            r_fill      <= n_fill;
            r_slots_cfg <= n_slots_cfg;
            r_var_cfg   <= n_var_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_rdata  <= n_out_rdata;
        r_out_moved  <= n_out_moved;
        r_addr       <= n_addr;
        r_data       <= n_data;
        r_old        <= n_old;
        r_i          <= n_i;
        r_cp_addr    <= n_cp_addr;
        r_cp_data    <= n_cp_data;
        if (w_tbl_we) begin
            r_table[w_tbl_idx] <= i_item.var_addr;
        end
    end

    fee_scan #(
        .PAGE_SLOTS (PAGE_SLOTS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_scan_start),
        .i_page    (w_scan_page),
        .i_addr    (w_scan_addr),
        .i_used    (w_used),
        .i_fill    (r_fill[w_scan_page]),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_rsp     (w_rsp)
    );

    fee_ram #(
        .WIDTH (32),
        .DEPTH (2 ** NW)
    ) u_pages (
        .i_clk     (i_clk),
        .i_wr_en   (w_wen),
        .i_wr_addr ({w_app_page, r_fill[w_app_page][SW-1:0]}),
        .i_wr_data (w_app_word),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

`ifndef SYNTHESIS
    a_one_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_hdr[0] == HDR_VALID) && (r_hdr[1] == HDR_VALID)))
        else $error("both pages marked valid");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_item.ready)
        else $error("item taken while busy");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_fill[0]) <= PAGE_SLOTS) && (int'(r_fill[1]) <= PAGE_SLOTS))
        else $error("fill mark beyond the page");
    a_no_wr_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wen |-> !((r_state == S_READ) || (r_state == S_XF_SCAN)))
        else $error("page write during a scan");
`endif
endmodule

`default_nettype wire
